// ===== rtl/core/xor_masked_base64_decoder_core_defines.svh =====
// Assertion helpers shared by the decoder core.
`ifndef XOR_MASKED_BASE64_DECODER_CORE_DEFINES_SVH
`define XOR_MASKED_BASE64_DECODER_CORE_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define XMB_ASSERT_NOW(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define XMB_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/xmb64_pkg.sv =====
package xmb64_pkg;

    // Highest byte count a string may decode to.
    localparam int KEY_LEN = 73;

    // Printable part of the key; positions past it read as zero.
    localparam int KEY_CHARS = 72;
    localparam logic [KEY_CHARS*8-1:0] KEY_STR =
        "~!:?$*<(qw2e5o7i8x12c6m67s98w43d2l45we82q3iuu1z4xle23rt4oxclle34e54u6r8m";

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ILLEGAL  = 3'd1,
        ST_PADS     = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_LONG     = 3'd4
    } status_t;

    // One unit of work handed from the front to the back: up to three
    // unmasked bytes, optionally followed by the end status.
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      count;
        logic            has_status;
        status_t         status;
    } job_t;

    function automatic logic [7:0] key_byte(input logic [6:0] idx);
        logic [7:0] r;
        r = '0;
        if (int'(idx) < KEY_CHARS) begin
            r = KEY_STR[(KEY_CHARS - 1 - int'(idx))*8 +: 8];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/xmb64_front.sv =====
module xmb64_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_symbol,
    input  logic               s_final_char,
    output logic               q_push,
    output xmb64_pkg::job_t    q_job,
    input  logic               q_full
);

    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [6:0] NO_SEXTET = 7'd64;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = NO_SEXTET;
        if (c >= CH_UA && c <= CH_UZ) begin
            r = 7'(c - CH_UA);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            r = 7'(c - CH_LA + 8'd26);
        end else if (c >= CH_D0 && c <= CH_D9) begin
            r = 7'(c - CH_D0 + 8'd52);
        end else if (c == CH_PLUS) begin
            r = 7'd62;
        end else if (c == CH_SLASH) begin
            r = 7'd63;
        end
        return r;
    endfunction

    logic [23:0]        acc_reg, acc_next;
    logic [1:0]         pos_reg, pos_next;
    logic [1:0]         pad_reg, pad_next;
    logic [6:0]         idx_reg, idx_next;
    xmb64_pkg::status_t err_reg, err_next;

    logic [6:0]         sextet;
    logic [1:0]         cnt;
    logic [2:0]         in_group;
    logic [2:0]         in_key;
    logic [1:0]         n_bytes;
    logic               take;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;
    assign sextet  = sextet_of(s_symbol);

    always_comb begin
        acc_next = acc_reg;
        pos_next = pos_reg;
        pad_next = pad_reg;
        idx_next = idx_reg;
        err_next = err_reg;
        cnt      = '0;
        n_bytes  = '0;
        in_group = '0;
        in_key   = '0;
        q_job    = '0;
        q_job.status = xmb64_pkg::ST_OK;

        if (err_reg == xmb64_pkg::ST_OK) begin
            if (s_symbol == CH_PAD) begin
                if (pad_reg >= 2'd2) begin
                    err_next = xmb64_pkg::ST_PADS;
                end else begin
                    pad_next = pad_reg + 2'd1;
                end
            end else if (sextet == NO_SEXTET) begin
                err_next = xmb64_pkg::ST_ILLEGAL;
            end
            if (err_next == xmb64_pkg::ST_OK) begin
                acc_next = {acc_reg[17:0], (s_symbol == CH_PAD) ? 6'd0 : sextet[5:0]};
                if (pos_reg == 2'd3) begin
                    cnt = 2'd3 - pad_next;
                    for (int k = 0; k < 3; k++) begin
                        in_group[k] = 2'(k) < cnt;
                        in_key[k]   = ({1'b0, idx_reg} + 8'(k)) < 8'(xmb64_pkg::KEY_LEN);
                        q_job.data[k] = acc_next[23 - 8*k -: 8]
                                      ^ xmb64_pkg::key_byte(7'(idx_reg + 7'(k)));
                    end
                    n_bytes = 2'(in_group[0] && in_key[0])
                            + 2'(in_group[1] && in_key[1])
                            + 2'(in_group[2] && in_key[2]);
                    if (|(in_group & ~in_key)) begin
                        err_next = xmb64_pkg::ST_LONG;
                    end
                    idx_next = idx_reg + 7'(n_bytes);
                    acc_next = '0;
                    pad_next = '0;
                    pos_next = '0;
                end else begin
                    pos_next = pos_reg + 2'd1;
                end
            end
        end

        q_job.count = n_bytes;

        if (s_final_char) begin
            if (err_next == xmb64_pkg::ST_OK && pos_next != 2'd0) begin
                err_next = xmb64_pkg::ST_LENGTH;
            end
            q_job.has_status = 1'b1;
            q_job.status     = err_next;
            acc_next = '0;
            pos_next = '0;
            pad_next = '0;
            idx_next = '0;
            err_next = xmb64_pkg::ST_OK;
        end
    end

    assign q_push = take && (n_bytes != 2'd0 || s_final_char);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            pos_reg <= '0;
            pad_reg <= '0;
            idx_reg <= '0;
            err_reg <= xmb64_pkg::ST_OK;
        end else if (take) begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            pad_reg <= pad_next;
            idx_reg <= idx_next;
            err_reg <= err_next;
        end
    end

endmodule

// ===== rtl/core/xmb64_queue.sv =====
`include "xor_masked_base64_decoder_core_defines.svh"

module xmb64_queue #(
    parameter int DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  xmb64_pkg::job_t    push_job,
    output logic               full,
    input  logic               pop,
    output xmb64_pkg::job_t    head_job,
    output logic               head_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    xmb64_pkg::job_t mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `XMB_ASSERT_NOW(a_count_bound, aclk, aresetn, count_reg <= CW'(DEPTH), "queue count overran depth")

endmodule

// ===== rtl/core/xmb64_back.sv =====
`include "xor_masked_base64_decoder_core_defines.svh"

module xmb64_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  xmb64_pkg::job_t    q_job,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_plain_byte,
    output logic               m_is_status,
    output logic [2:0]         m_status_code,
    output logic               m_end_of_run
);

    xmb64_pkg::job_t cur_reg;
    logic            cur_valid_reg;
    logic [1:0]      pos_reg;

    logic            m_valid_reg;
    logic [7:0]      m_plain_byte_reg;
    logic            m_is_status_reg;
    logic [2:0]      m_status_code_reg;
    logic            m_end_of_run_reg;

    logic            out_free;
    logic            is_data;
    logic            last_beat;
    logic            advance;

    assign out_free  = !m_valid_reg || m_ready;
    assign is_data   = pos_reg < cur_reg.count;
    assign last_beat = is_data ? (pos_reg == cur_reg.count - 2'd1) && !cur_reg.has_status
                               : 1'b1;
    assign advance   = out_free && cur_valid_reg;
    assign q_pop     = q_valid && (!cur_valid_reg || (advance && last_beat));

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_plain_byte_reg  <= is_data ? cur_reg.data[pos_reg] : 8'd0;
            m_is_status_reg   <= !is_data;
            m_status_code_reg <= is_data ? 3'(xmb64_pkg::ST_OK) : 3'(cur_reg.status);
            m_end_of_run_reg  <= !is_data;
        end
        if (q_pop) begin
            cur_reg <= q_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else begin
            if (out_free) begin
                m_valid_reg <= cur_valid_reg;
            end
            // Load the next job as the last beat of the current one leaves.
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                pos_reg       <= '0;
            end else if (advance) begin
                if (last_beat) begin
                    cur_valid_reg <= 1'b0;
                    pos_reg       <= '0;
                end else begin
                    pos_reg <= pos_reg + 2'd1;
                end
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_plain_byte  = m_plain_byte_reg;
    assign m_is_status   = m_is_status_reg;
    assign m_status_code = m_status_code_reg;
    assign m_end_of_run  = m_end_of_run_reg;

    `XMB_ASSERT_IMPLIES(a_pos_in_job, aclk, aresetn, cur_valid_reg, pos_reg <= cur_reg.count, "position ran past job")
    `XMB_ASSERT_IMPLIES(a_status_shape, aclk, aresetn, m_valid_reg && m_is_status_reg, m_end_of_run_reg && m_plain_byte_reg == 8'd0, "status beat malformed")
    `XMB_ASSERT_IMPLIES(a_data_shape, aclk, aresetn, m_valid_reg && !m_is_status_reg, m_status_code_reg == 3'(xmb64_pkg::ST_OK) && !m_end_of_run_reg, "data beat carries status")

endmodule

// ===== rtl/core/xor_masked_base64_decoder_core.sv =====
// Base64 decoder with key unmasking. One character is taken per cycle on the
// s_ channel while s_ready is high; each fourth character of a group releases
// up to three bytes, each XORed with the key byte at its running index, and
// the character marked final adds one status beat (0 ok, 1 illegal character,
// 2 too many pads, 3 bad length, 4 too long) with end_of_run set. The front
// decodes and masks a whole group in the cycle its last character arrives and
// writes it as one job into a QUEUE_DEPTH-entry queue; the back drains jobs
// at one beat per cycle while m_ready allows, through a registered m_ output.
// A character that produces no output pushes no job; s_ready drops only while
// the job queue is full, which happens when m_ready stalls or a burst of final
// characters outruns the one-beat-per-cycle drain. The first result passes
// through the queue, the back's job register and the output register.
module xor_masked_base64_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_symbol,
    input  logic        s_final_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_plain_byte,
    output logic        m_is_status,
    output logic [2:0]  m_status_code,
    output logic        m_end_of_run
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    xmb64_pkg::job_t push_job;
    xmb64_pkg::job_t head_job;

    xmb64_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_symbol     (s_symbol),
        .s_final_char (s_final_char),
        .q_push       (q_push),
        .q_job        (push_job),
        .q_full       (q_full)
    );

    xmb64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_job   (head_job),
        .head_valid (q_valid)
    );

    xmb64_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_job         (head_job),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_plain_byte  (m_plain_byte),
        .m_is_status   (m_is_status),
        .m_status_code (m_status_code),
        .m_end_of_run  (m_end_of_run)
    );

endmodule
